// ----- hdl/cas_pkg.sv -----
// shared types and constants of the cave smoothing unit
// no dependencies; imported by every module of the block
`default_nettype none

package cas_pkg;

  // geometry limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned MaxPasses = 4;

  // column and row position of a cell; rows run past the frame during flush
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight + MaxPasses + 2);

  // register field widths
  localparam int unsigned DimW     = 11;
  localparam int unsigned BandW    = 9;
  localparam int unsigned ThrW     = 4;
  localparam int unsigned PassW    = 3;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned TdataW   = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth,
    CfgGridHeight,
    CfgBorderCols,
    CfgBorderRows,
    CfgThreshold,
    CfgPasses
  } cas_cfg_reg_e;

  // geometry in use, already clamped
  typedef struct packed {
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [BandW-1:0] bcols;
    logic [BandW-1:0] brows;
    logic [ThrW-1:0]  thresh;
  } cas_geom_t;

  // one cell moving down the pass chain
  typedef struct packed {
    logic            vld;    // slot holds a beat
    logic            ok;     // stream index at this pass is not negative
    logic            live;   // index lies inside the frame
    logic            last;   // index is the final cell of the frame
    logic            solid;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } cas_tok_t;

  typedef struct packed {
    logic solid;
    logic last;
  } cas_res_t;

endpackage

`default_nettype wire

// ----- hdl/cas_pass.sv -----
// one smoothing pass: two-row line buffer memory, 3x3 window and rule
// depends on cas_pkg
`default_nettype none

module cas_pass
  import cas_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      clear_i,
  input  wire logic      active_i,
  input  wire cas_geom_t geom_i,
  input  wire cas_tok_t  tok_i,
  output cas_tok_t       tok_o
);

  // line buffer: bit 0 is the row above the incoming one, bit 1 two rows above
  logic [1:0] lb_mem [MaxWidth];
  logic [1:0] rd_q;

  cas_tok_t tok_b_q;
  cas_tok_t tok_o_q;
  cas_tok_t tok_o_d;

  logic [2:0] win_a_q;  // column two beats back
  logic [2:0] win_b_q;  // column one beat back

  logic            rd_en;
  logic            wr_en;
  logic [2:0]      col_new;
  logic [2:0]      lc;
  logic [2:0]      mc;
  logic [2:0]      rc;
  logic [ColW-1:0] cx;
  logic [RowW-1:0] cy;
  logic            c_ok;
  logic            x_first;
  logic            x_final;
  logic            y_first;
  logic            y_final;
  logic            in_band;
  logic [CntW-1:0] cnt;
  logic            smoothed;

  assign rd_en = en_i && !clear_i && active_i && tok_i.vld && tok_i.ok;
  assign wr_en = en_i && !clear_i && active_i && tok_b_q.vld && tok_b_q.ok;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= lb_mem[tok_i.col];
    end
    if (wr_en) begin
      lb_mem[tok_b_q.col] <= {rd_q[0], tok_b_q.solid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q <= '0;
      win_b_q <= '0;
    end else if (wr_en) begin
      win_a_q <= win_b_q;
      win_b_q <= col_new;
    end
  end

  always_comb begin
    col_new = {rd_q, tok_b_q.solid};

    // centre sits one row and one column behind the incoming cell
    if (tok_b_q.col == '0) begin
      cx = ColW'(geom_i.width - DimW'(1));
      cy = tok_b_q.row - RowW'(2);
    end else begin
      cx = tok_b_q.col - ColW'(1);
      cy = tok_b_q.row - RowW'(1);
    end
    c_ok = tok_b_q.ok && ((tok_b_q.row > RowW'(1)) ||
                          ((tok_b_q.row == RowW'(1)) && (tok_b_q.col != '0)));

    x_first = (cx == '0);
    x_final = (DimW'(cx) == geom_i.width - DimW'(1));
    y_first = (cy == '0);
    y_final = (cy == RowW'(geom_i.height) - RowW'(1));

    // neighbours off the map count as solid
    lc = x_first ? 3'b111 : win_a_q;
    mc = win_b_q;
    rc = x_final ? 3'b111 : col_new;
    if (y_first) begin
      lc[2] = 1'b1;
      mc[2] = 1'b1;
      rc[2] = 1'b1;
    end
    if (y_final) begin
      lc[0] = 1'b1;
      mc[0] = 1'b1;
      rc[0] = 1'b1;
    end

    cnt = '0;
    for (int k = 0; k < 3; k++) begin
      cnt = cnt + CntW'(lc[k]) + CntW'(mc[k]) + CntW'(rc[k]);
    end

    in_band = (DimW'(cx) < DimW'(geom_i.bcols)) ||
              ((DimW'(cx) + DimW'(geom_i.bcols)) >= geom_i.width) ||
              (cy < RowW'(geom_i.brows)) ||
              (((RowW+1)'(cy) + (RowW+1)'(geom_i.brows)) >= (RowW+1)'(geom_i.height));

    if (in_band) begin
      smoothed = 1'b1;
    end else if (cnt > geom_i.thresh) begin
      smoothed = 1'b1;
    end else if (cnt < geom_i.thresh) begin
      smoothed = 1'b0;
    end else begin
      smoothed = win_b_q[1];
    end

    if (active_i) begin
      tok_o_d.vld   = tok_b_q.vld;
      tok_o_d.ok    = c_ok;
      tok_o_d.live  = (cy < RowW'(geom_i.height));
      tok_o_d.last  = x_final && y_final;
      tok_o_d.solid = smoothed;
      tok_o_d.col   = cx;
      tok_o_d.row   = cy;
    end else begin
      tok_o_d = tok_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_b_q <= '0;
      tok_o_q <= '0;
    end else if (clear_i) begin
      tok_b_q.vld <= 1'b0;
      tok_o_q.vld <= 1'b0;
    end else if (en_i) begin
      tok_b_q <= tok_i;
      tok_o_q <= tok_o_d;
    end
  end

  assign tok_o = tok_o_q;

  // within a frame the reader is one column ahead of the writer
  a_no_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en && (tok_i.row != '0)) |-> (tok_i.col != tok_b_q.col))
    else $error("line buffer read and write hit the same column");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_i |-> !wr_en)
    else $error("bypassed pass wrote its line buffer");

  a_clear_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (!tok_b_q.vld && !tok_o_q.vld))
    else $error("pass kept a beat across a restart");

endmodule

`default_nettype wire

// ----- hdl/cas_out_fifo.sv -----
// two-entry result buffer that decouples the pass chain from the receiver
// depends on cas_pkg
`default_nettype none

module cas_out_fifo
  import cas_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     clear_i,
  input  wire logic     push_i,
  input  wire cas_res_t res_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output cas_res_t      res_o,
  output logic          full_o
);

  cas_res_t   head_q;
  cas_res_t   tail_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i && pop) begin
      if (count_q == 2'd1) begin
        head_q <= res_i;
      end else begin
        head_q <= tail_q;
        tail_q <= res_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_q <= res_i;
      end else begin
        tail_q <= res_i;
      end
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (clear_i) begin
      count_q <= 2'd0;
    end else if (push_i && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_q <= count_q - 2'd1;
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign res_o       = head_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (count_q == 2'd0))
    else $error("result buffer not empty after restart");

endmodule

`default_nettype wire

// ----- hdl/cave_automaton_smoothing_unit.sv -----
// top level of the cave smoothing unit: config registers, frame counter,
// chain of smoothing passes and result buffer
// depends on cas_pkg, cas_pass, cas_out_fifo
//
// usage
//  - cells of a solid/open grid enter on the s_axis side in raster order,
//    one beat per cell; tuser marks a pad beat. after the width*height cells
//    the sender adds passes*(width+1) flush beats, each giving one result
//  - a pad beat inside the frame is a bubble: no effect, no result
//  - smoothed cells leave on m_axis in raster order, tlast on the final cell;
//    after the final flush beat the next input beat starts a new frame
//  - throughput: one beat per cycle on both sides while the result buffer is not full
//  - the result released by an input beat reaches m_axis through the input
//    register, two register stages per pass (unused passes keep theirs as
//    bypass), then the result buffer
//  - each pass keeps its two previous rows in a line buffer memory with
//    one read and one write per cycle
//  - a two-entry result buffer parts the chain from the receiver: input is
//    still taken while one result waits; the whole chain holds once it is full
//  - reset loads the default geometry (64x64, bands of 1, threshold 4,
//    4 passes) and empties the chain; line buffers need no clearing
//  - any config beat restarts the frame and drops results still in flight
`default_nettype none

module cave_automaton_smoothing_unit
  import cas_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // cell input
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [TdataW-1:0]   s_axis_tdata,   // [0] cell_solid, [7:1] zero
  input  wire logic                s_axis_tuser,   // [0] is_pad
  // smoothed output
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [TdataW-1:0]        m_axis_tdata,   // [0] smoothed_solid, [7:1] zero
  output logic                     m_axis_tlast
);

  // config registers as written
  logic [DimW-1:0]  grid_width_q;
  logic [DimW-1:0]  grid_height_q;
  logic [BandW-1:0] border_cols_q;
  logic [BandW-1:0] border_rows_q;
  logic [ThrW-1:0]  threshold_q;
  logic [PassW-1:0] passes_q;

  logic cfg_we;

  // geometry in use
  cas_geom_t        geom;
  logic [PassW-1:0] npass;

  // input position counter
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] end_col;
  logic [RowW-1:0] end_row;

  logic     en;
  logic     live_in;
  logic     take;
  logic     fifo_full;
  cas_tok_t tok_in_q;
  cas_tok_t tok_chain [MaxPasses+1];
  cas_tok_t tok_fin;
  cas_res_t res_push;
  cas_res_t res_head;
  logic     push;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DimW'(64);
      grid_height_q <= DimW'(64);
      border_cols_q <= BandW'(1);
      border_rows_q <= BandW'(1);
      threshold_q   <= ThrW'(4);
      passes_q      <= PassW'(4);
    end else if (cfg_we) begin
      case (cas_cfg_reg_e'(cfg_index_i))
        CfgGridWidth:  grid_width_q  <= cfg_data_i[DimW-1:0];
        CfgGridHeight: grid_height_q <= cfg_data_i[DimW-1:0];
        CfgBorderCols: border_cols_q <= cfg_data_i[BandW-1:0];
        CfgBorderRows: border_rows_q <= cfg_data_i[BandW-1:0];
        CfgThreshold:  threshold_q   <= cfg_data_i[ThrW-1:0];
        CfgPasses:     passes_q      <= cfg_data_i[PassW-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size and pass count to the supported range; bands and threshold pass through
  always_comb begin
    if (grid_width_q < DimW'(3)) begin
      geom.width = DimW'(3);
    end else if (grid_width_q > DimW'(MaxWidth)) begin
      geom.width = DimW'(MaxWidth);
    end else begin
      geom.width = grid_width_q;
    end
    if (grid_height_q < DimW'(3)) begin
      geom.height = DimW'(3);
    end else if (grid_height_q > DimW'(MaxHeight)) begin
      geom.height = DimW'(MaxHeight);
    end else begin
      geom.height = grid_height_q;
    end
    geom.bcols  = border_cols_q;
    geom.brows  = border_rows_q;
    geom.thresh = threshold_q;
    npass = (passes_q > PassW'(MaxPasses)) ? PassW'(MaxPasses) : passes_q;
  end

  // position of the final flush beat: last cell plus passes*(width+1)
  always_comb begin
    if (npass == '0) begin
      end_col = ColW'(geom.width - DimW'(1));
      end_row = RowW'(geom.height) - RowW'(1);
    end else if ((DimW'(npass) - DimW'(1)) >= geom.width) begin
      end_col = ColW'(DimW'(npass) - DimW'(1) - geom.width);
      end_row = RowW'(geom.height) + RowW'(npass) + RowW'(1);
    end else begin
      end_col = ColW'(DimW'(npass) - DimW'(1));
      end_row = RowW'(geom.height) + RowW'(npass);
    end
  end

  // whole chain moves together; only a full result buffer holds it
  assign en            = !fifo_full;
  assign s_axis_tready = en;

  // pad beats inside the frame are bubbles
  assign live_in = (row_q < RowW'(geom.height));
  assign take    = s_axis_tvalid && s_axis_tready && !(s_axis_tuser && live_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      tok_in_q <= '0;
    end else if (cfg_we) begin
      col_q        <= '0;
      row_q        <= '0;
      tok_in_q.vld <= 1'b0;
    end else if (en) begin
      tok_in_q.vld   <= take;
      tok_in_q.ok    <= 1'b1;
      tok_in_q.live  <= live_in;
      tok_in_q.last  <= (DimW'(col_q) == geom.width - DimW'(1)) &&
                        (row_q == RowW'(geom.height) - RowW'(1));
      tok_in_q.solid <= s_axis_tdata[0] && live_in;
      tok_in_q.col   <= col_q;
      tok_in_q.row   <= row_q;
      if (take) begin
        if ((col_q == end_col) && (row_q == end_row)) begin
          // frame done, next beat starts over
          col_q <= '0;
          row_q <= '0;
        end else if (DimW'(col_q) == geom.width - DimW'(1)) begin
          col_q <= '0;
          row_q <= row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
    end
  end

  assign tok_chain[0] = tok_in_q;

  // cascaded passes; those at or beyond the pass count act as plain delay
  for (genvar s = 0; s < MaxPasses; s++) begin : g_pass
    cas_pass u_pass (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .clear_i  (cfg_we),
      .active_i (npass > PassW'(s)),
      .geom_i   (geom),
      .tok_i    (tok_chain[s]),
      .tok_o    (tok_chain[s+1])
    );
  end

  assign tok_fin        = tok_chain[MaxPasses];
  assign push           = en && !cfg_we && tok_fin.vld && tok_fin.ok && tok_fin.live;
  assign res_push.solid = tok_fin.solid;
  assign res_push.last  = tok_fin.last;

  cas_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we),
    .push_i      (push),
    .res_i       (res_push),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_head),
    .full_o      (fifo_full)
  );

  assign m_axis_tdata = {{(TdataW-1){1'b0}}, res_head.solid};
  assign m_axis_tlast = res_head.last;

endmodule

`default_nettype wire
